// ===== hdl/lstp_pkg.sv =====
package lstp_pkg;

  // Framing bytes
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_SEP = 8'h20;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Channel content types
  localparam logic [2:0] TYPE_DIST1   = 3'd0;
  localparam logic [2:0] TYPE_DIST2   = 3'd1;
  localparam logic [2:0] TYPE_RSSI1   = 3'd2;
  localparam logic [2:0] TYPE_RSSI2   = 3'd3;
  localparam logic [2:0] TYPE_UNKNOWN = 3'd4;

  localparam int unsigned NAME_LEN = 5;
  localparam logic [16:0] ACC_CAP  = 17'd65536;

  // Register map
  localparam logic REG_HEADER_SKIP = 1'b0;
  localparam logic [5:0] HEADER_SKIP_RST = 6'd18;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_ENC_COUNT, PH_ENC_POS, PH_ENC_SPEED, PH_CH_COUNT,
    PH_NAME, PH_CH_SKIP, PH_NCOUNT, PH_DATA, PH_DONE
  } phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  channel_type;
    logic        eight_bit_group;
    logic [10:0] point_index;
    logic [15:0] value;
    logic        last;
  } res_t;

  // One result slot out of the parser
  typedef struct packed {
    logic vld;
    res_t res;
  } slot_t;

  // Parser status seen by the top level
  typedef struct packed {
    logic   in_frame;
    phase_e phase;
  } stat_t;

  // Character k of content name at position pos
  function automatic logic [7:0] name_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = k[1] ? "R" : "D";
      3'd1:    c = k[1] ? "S" : "I";
      3'd2:    c = "S";
      3'd3:    c = k[1] ? "I" : "T";
      3'd4:    c = k[0] ? "2" : "1";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/lstp_if.sv =====
// Byte request channel
interface lstp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// Parsed result channel
interface lstp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  channel_type;
  logic        eight_bit_group;
  logic [10:0] point_index;
  logic [15:0] value;
  logic        last;

  modport source (output valid, output kind, output channel_type, output eight_bit_group,
                  output point_index, output value, output last, input ready);
  modport sink   (input valid, input kind, input channel_type, input eight_bit_group,
                  input point_index, input value, input last, output ready);
endinterface

// ===== hdl/lstp_parse.sv =====
// Telegram parser state and per-byte step logic.
module lstp_parse #(
  parameter int unsigned MAX_POINTS = 2048,
  parameter int unsigned MAX_COUNT  = 255
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic [5:0]      header_skip_i,
  output lstp_pkg::slot_t tok_o,
  output lstp_pkg::slot_t end_o,
  output lstp_pkg::stat_t stat_o
);
  import lstp_pkg::*;

  localparam int unsigned DW = $clog2(MAX_POINTS + 1);
  localparam logic [16:0] PTS_CAP = 17'(MAX_POINTS);
  localparam logic [16:0] CNT_CAP = 17'(MAX_COUNT);

  logic          in_frame_q, in_frame_d;
  phase_e        phase_q, phase_d;
  logic          tok_act_q, tok_act_d;
  logic [7:0]    skip_q, skip_d;
  logic [7:0]    chans_q, chans_d;
  logic          grp8_q, grp8_d;
  logic [2:0]    ctype_q, ctype_d;
  logic [2:0]    npos_q, npos_d;
  logic [3:0]    nlive_q, nlive_d;
  logic [DW-1:0] dleft_q, dleft_d;
  logic [10:0]   didx_q, didx_d;
  logic [16:0]   acc_q, acc_d;

  // Step logic: finish token, take character, or framing
  always_comb begin
    logic [4:0]  dig;
    logic        dig_ok;
    logic [20:0] acc_w;
    logic [16:0] cnt_v;
    logic [16:0] pts_v;
    in_frame_d = in_frame_q;
    phase_d    = phase_q;
    tok_act_d  = tok_act_q;
    skip_d     = skip_q;
    chans_d    = chans_q;
    grp8_d     = grp8_q;
    ctype_d    = ctype_q;
    npos_d     = npos_q;
    nlive_d    = nlive_q;
    dleft_d    = dleft_q;
    didx_d     = didx_q;
    acc_d      = acc_q;
    tok_o      = '0;
    end_o      = '0;
    dig        = '0;
    dig_ok     = 1'b0;
    acc_w      = '0;
    cnt_v      = (acc_q > CNT_CAP) ? CNT_CAP : acc_q;
    pts_v      = (acc_q > PTS_CAP) ? PTS_CAP : acc_q;

    if (step_i) begin
      priority if (byte_i == BYTE_STX) begin
        in_frame_d = 1'b1;
        tok_act_d  = 1'b0;
        skip_d     = {2'b00, header_skip_i};
        phase_d    = (header_skip_i != '0) ? PH_HEADER : PH_ENC_COUNT;
        chans_d    = '0;
        grp8_d     = 1'b0;
        ctype_d    = TYPE_UNKNOWN;
        npos_d     = '0;
        nlive_d    = 4'hF;
        dleft_d    = '0;
        didx_d     = '0;
        acc_d      = '0;
      end else if (!in_frame_q) begin
        // bytes outside a frame are dropped
      end else if (byte_i == BYTE_SEP || byte_i == BYTE_ETX) begin
        // close the running token
        if (tok_act_q) begin
          unique case (phase_q)
            PH_HEADER: begin
              if (skip_q != '0) skip_d = skip_q - 8'd1;
              if (skip_q <= 8'd1) phase_d = PH_ENC_COUNT;
            end
            PH_ENC_COUNT: begin
              skip_d  = cnt_v[7:0];
              phase_d = (cnt_v != '0) ? PH_ENC_POS : PH_CH_COUNT;
            end
            PH_ENC_POS: phase_d = PH_ENC_SPEED;
            PH_ENC_SPEED: begin
              if (skip_q != '0) skip_d = skip_q - 8'd1;
              phase_d = (skip_q > 8'd1) ? PH_ENC_POS : PH_CH_COUNT;
            end
            PH_CH_COUNT: begin
              chans_d = cnt_v[7:0];
              if (cnt_v == '0) begin
                grp8_d  = 1'b1;
                phase_d = grp8_q ? PH_DONE : PH_CH_COUNT;
              end else begin
                phase_d = PH_NAME;
              end
            end
            PH_NAME: begin
              ctype_d = TYPE_UNKNOWN;
              if (npos_q == 3'(NAME_LEN)) begin
                unique case (nlive_q)
                  4'b0001: ctype_d = TYPE_DIST1;
                  4'b0010: ctype_d = TYPE_DIST2;
                  4'b0100: ctype_d = TYPE_RSSI1;
                  4'b1000: ctype_d = TYPE_RSSI2;
                  default: ctype_d = TYPE_UNKNOWN;
                endcase
              end
              skip_d  = 8'd4;
              phase_d = PH_CH_SKIP;
            end
            PH_CH_SKIP: begin
              if (skip_q != '0) skip_d = skip_q - 8'd1;
              if (skip_q <= 8'd1) phase_d = PH_NCOUNT;
            end
            PH_NCOUNT: begin
              dleft_d   = pts_v[DW-1:0];
              didx_d    = '0;
              tok_o.vld = 1'b1;
              tok_o.res = '{kind: KIND_HEADER, channel_type: ctype_q,
                            eight_bit_group: grp8_q, point_index: 11'd0,
                            value: pts_v[16] ? 16'hFFFF : pts_v[15:0],
                            last: (pts_v == '0)};
              if (pts_v == '0) begin
                // empty channel: move on
                if (chans_q != '0) chans_d = chans_q - 8'd1;
                if (chans_q <= 8'd1) begin
                  grp8_d  = 1'b1;
                  phase_d = grp8_q ? PH_DONE : PH_CH_COUNT;
                end else begin
                  phase_d = PH_NAME;
                end
              end else begin
                phase_d = PH_DATA;
              end
            end
            PH_DATA: begin
              tok_o.vld = 1'b1;
              tok_o.res = '{kind: KIND_DATA, channel_type: ctype_q,
                            eight_bit_group: grp8_q, point_index: didx_q,
                            value: acc_q[16] ? 16'hFFFF : acc_q[15:0],
                            last: (dleft_q == DW'(1))};
              didx_d = didx_q + 11'd1;
              if (dleft_q != '0) dleft_d = dleft_q - DW'(1);
              if (dleft_q <= DW'(1)) begin
                if (chans_q != '0) chans_d = chans_q - 8'd1;
                if (chans_q <= 8'd1) begin
                  grp8_d  = 1'b1;
                  phase_d = grp8_q ? PH_DONE : PH_CH_COUNT;
                end else begin
                  phase_d = PH_NAME;
                end
              end
            end
            default: ;
          endcase
          tok_act_d = 1'b0;
          acc_d     = '0;
          npos_d    = '0;
          nlive_d   = 4'hF;
        end
        // frame end follows any closed token
        if (byte_i == BYTE_ETX) begin
          end_o.vld  = 1'b1;
          end_o.res  = '{kind: KIND_END, channel_type: TYPE_UNKNOWN, eight_bit_group: 1'b0,
                         point_index: 11'd0, value: 16'd0, last: 1'b1};
          in_frame_d = 1'b0;
          phase_d    = PH_IDLE;
          tok_act_d  = 1'b0;
          acc_d      = '0;
          npos_d     = '0;
          nlive_d    = 4'hF;
        end
      end else begin
        // token character
        tok_act_d = 1'b1;
        if (phase_q == PH_NAME) begin
          if (npos_q < 3'(NAME_LEN)) begin
            for (int k = 0; k < 4; k++) begin
              if (name_char(2'(k), npos_q) != byte_i) nlive_d[k] = 1'b0;
            end
            npos_d = npos_q + 3'd1;
          end else begin
            nlive_d = '0;
          end
        end else begin
          if (byte_i >= "0" && byte_i <= "9") begin
            dig    = 5'(byte_i - "0");
            dig_ok = 1'b1;
          end else if (phase_q == PH_NCOUNT || phase_q == PH_DATA) begin
            if (byte_i >= "A" && byte_i <= "F") begin
              dig    = 5'(byte_i - "A" + 8'd10);
              dig_ok = 1'b1;
            end else if (byte_i >= "a" && byte_i <= "f") begin
              dig    = 5'(byte_i - "a" + 8'd10);
              dig_ok = 1'b1;
            end
          end
          if (dig_ok) begin
            if (phase_q == PH_ENC_COUNT || phase_q == PH_CH_COUNT) begin
              acc_w = 21'(acc_q) * 21'd10 + 21'(dig);
              acc_d = (acc_w > 21'(ACC_CAP)) ? ACC_CAP : acc_w[16:0];
            end else if (phase_q == PH_NCOUNT || phase_q == PH_DATA) begin
              acc_w = {acc_q, 4'h0} + 21'(dig);
              acc_d = (acc_w > 21'(ACC_CAP)) ? ACC_CAP : acc_w[16:0];
            end
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      phase_q    <= PH_IDLE;
      tok_act_q  <= 1'b0;
      skip_q     <= '0;
      chans_q    <= '0;
      grp8_q     <= 1'b0;
      ctype_q    <= TYPE_UNKNOWN;
      npos_q     <= '0;
      nlive_q    <= 4'hF;
      dleft_q    <= '0;
      didx_q     <= '0;
      acc_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      phase_q    <= phase_d;
      tok_act_q  <= tok_act_d;
      skip_q     <= skip_d;
      chans_q    <= chans_d;
      grp8_q     <= grp8_d;
      ctype_q    <= ctype_d;
      npos_q     <= npos_d;
      nlive_q    <= nlive_d;
      dleft_q    <= dleft_d;
      didx_q     <= didx_d;
      acc_q      <= acc_d;
    end
  end

  assign stat_o = '{in_frame: in_frame_q, phase: phase_q};

endmodule

// ===== hdl/lidar_scan_telegram_parser_top.sv =====
// Channel    | Dir | Payload                                          | Notes
// in_if      | in  | byte_in[7:0]                                     | one telegram byte
// out_if     | out | kind, channel_type, eight_bit_group,            | header, value or
//            |     | point_index[10:0], value[15:0], last             | frame end
// APB        | in  | header_skip at byte address 0                    | pready tied high
//
// One byte per cycle sustained while the result queue has room; a byte is parsed
// while it sits in the input register and its results enter a 4-entry result
// queue at the next edge, from which they are offered.
// A byte may yield up to two results (token close plus frame end), so the
// input register drains only while the queue has two free entries.
// Reset puts the parser outside any frame with header_skip at 18.
module lidar_scan_telegram_parser_top #(
  parameter int unsigned MAX_POINTS = 2048,
  parameter int unsigned MAX_COUNT  = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lstp_byte_if.sink   in_if,
  lstp_res_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lstp_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [5:0]    hskip_q;
  logic [7:0]    byte_q;
  logic          bvld_q;
  logic          step;
  slot_t         tok, fend;
  stat_t         stat;
  res_t          fifo_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          pop;
  logic [1:0]    npush;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hskip_q <= HEADER_SKIP_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_HEADER_SKIP) begin
      hskip_q <= pwdata[5:0];
    end
  end
  assign prdata = (paddr[2] == REG_HEADER_SKIP) ? {26'd0, hskip_q} : 32'd0;

  // Input register
  assign step        = bvld_q && (cnt_q <= CW'(DEPTH - 2));
  assign in_if.ready = !bvld_q || step;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      bvld_q <= 1'b1;
    end else if (step) begin
      bvld_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) byte_q <= in_if.byte_in;
  end

  lstp_parse #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_COUNT (MAX_COUNT)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (byte_q),
    .header_skip_i(hskip_q),
    .tok_o        (tok),
    .end_o        (fend),
    .stat_o       (stat)
  );

  // Result queue: token result first, frame end after it
  assign pop   = out_if.valid && out_if.ready;
  assign npush = 2'(tok.vld) + 2'(fend.vld);
  always_ff @(posedge clk_i) begin
    if (tok.vld) fifo_q[wr_q] <= tok.res;
    if (fend.vld) fifo_q[wr_q + PW'(tok.vld)] <= fend.res;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PW'(npush);
      rd_q  <= rd_q + PW'(pop);
      cnt_q <= cnt_q + CW'(npush) - CW'(pop);
    end
  end

  assign out_if.valid           = (cnt_q != '0);
  assign out_if.kind            = fifo_q[rd_q].kind;
  assign out_if.channel_type    = fifo_q[rd_q].channel_type;
  assign out_if.eight_bit_group = fifo_q[rd_q].eight_bit_group;
  assign out_if.point_index     = fifo_q[rd_q].point_index;
  assign out_if.value           = fifo_q[rd_q].value;
  assign out_if.last            = fifo_q[rd_q].last;

  // Checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok.vld || fend.vld) |-> cnt_q <= CW'(DEPTH - 2))
    else $error("results pushed without room");

  a_end_leaves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fend.vld |=> !stat.in_frame && stat.phase == PH_IDLE)
    else $error("frame end did not leave the frame");

endmodule

// ===== verif/lidar_scan_telegram_parser_top_tb.sv =====
module lidar_scan_telegram_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lstp_pkg::*;

  localparam int unsigned MAX_PTS = 2048;
  localparam int unsigned MAX_CNT = 255;
  localparam int unsigned SETTLE = 8;       // pipeline depth plus margin
  localparam int unsigned RX_HOLD = 300;    // long receiver hold-off
  localparam int unsigned WDOG_LIMIT = 2000;
  localparam int unsigned RAND_BYTES = 30;  // per random header_skip setting

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lstp_byte_if in_if ();
  lstp_res_if  out_if ();

  lidar_scan_telegram_parser_top #(
    .MAX_POINTS(MAX_PTS),
    .MAX_COUNT (MAX_CNT)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  string content_tab[4] = '{"DIST1", "DIST2", "RSSI1", "RSSI2"};

  // Telegram parser state as the testbench tracks it
  logic [5:0]  hdr_skip = HEADER_SKIP_RST;
  logic        in_frm = 1'b0;
  phase_e      ph = PH_IDLE;
  logic        tok_on = 1'b0;
  int unsigned skip_cnt = 0;
  int unsigned chan_cnt = 0;
  logic        grp8 = 1'b0;
  logic [2:0]  cur_type = TYPE_UNKNOWN;
  logic [3:0]  live = 4'hF;
  int unsigned npos = 0;
  int unsigned data_cnt = 0;
  int unsigned data_idx = 0;
  int unsigned acc = 0;

  res_t        parsed_q[$];   // results still owed by the block
  logic [7:0]  tele[$];       // telegram bytes being assembled
  int unsigned n_err = 0;
  int unsigned n_sent = 0;
  int unsigned quiet = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser tracking
  // ---------------------------------------------------------------------------
  function automatic void push_result(input logic [1:0] kind, input logic [2:0] ty,
                                      input logic g, input int unsigned idx,
                                      input int unsigned val, input logic lst);
    res_t r;
    r.kind            = kind;
    r.channel_type    = ty;
    r.eight_bit_group = g;
    r.point_index     = idx[10:0];
    r.value           = val[15:0];
    r.last            = lst;
    parsed_q.push_back(r);
  endfunction

  function automatic void close_group();
    if (!grp8) begin
      grp8 = 1'b1;
      ph   = PH_CH_COUNT;
    end else begin
      ph = PH_DONE;
    end
  endfunction

  function automatic void next_chan();
    if (chan_cnt > 0) chan_cnt--;
    if (chan_cnt == 0) close_group();
    else ph = PH_NAME;
  endfunction

  // One non-separator byte inside a frame
  function automatic void absorb_char(input logic [7:0] b);
    int d;
    d = -1;
    tok_on = 1'b1;
    if (ph == PH_NAME) begin
      if (npos < NAME_LEN) begin
        for (int k = 0; k < 4; k++)
          if (content_tab[k][npos] != b) live[k] = 1'b0;
        npos++;
      end else begin
        live = 4'h0;
      end
      return;
    end
    if (b >= "0" && b <= "9") d = b - "0";
    else if (ph == PH_NCOUNT || ph == PH_DATA) begin
      if (b >= "A" && b <= "F") d = b - "A" + 10;
      else if (b >= "a" && b <= "f") d = b - "a" + 10;
    end
    if (d < 0) return;
    if (ph == PH_ENC_COUNT || ph == PH_CH_COUNT) acc = acc * 10 + d;
    else if (ph == PH_NCOUNT || ph == PH_DATA) acc = acc * 16 + d;
    else return;
    if (acc > ACC_CAP) acc = ACC_CAP;
  endfunction

  // Token boundary: act on the token just finished
  function automatic void close_token();
    int unsigned v;
    if (!tok_on) return;
    case (ph)
      PH_HEADER: begin
        if (skip_cnt > 0) skip_cnt--;
        if (skip_cnt == 0) ph = PH_ENC_COUNT;
      end
      PH_ENC_COUNT: begin
        v = (acc > MAX_CNT) ? MAX_CNT : acc;
        skip_cnt = v;
        ph = (v != 0) ? PH_ENC_POS : PH_CH_COUNT;
      end
      PH_ENC_POS: ph = PH_ENC_SPEED;
      PH_ENC_SPEED: begin
        if (skip_cnt > 0) skip_cnt--;
        ph = (skip_cnt != 0) ? PH_ENC_POS : PH_CH_COUNT;
      end
      PH_CH_COUNT: begin
        v = (acc > MAX_CNT) ? MAX_CNT : acc;
        chan_cnt = v;
        if (v == 0) close_group();
        else ph = PH_NAME;
      end
      PH_NAME: begin
        cur_type = TYPE_UNKNOWN;
        if (npos == NAME_LEN) begin
          case (live)
            4'b0001: cur_type = TYPE_DIST1;
            4'b0010: cur_type = TYPE_DIST2;
            4'b0100: cur_type = TYPE_RSSI1;
            4'b1000: cur_type = TYPE_RSSI2;
            default: cur_type = TYPE_UNKNOWN;
          endcase
        end
        skip_cnt = 4;
        ph = PH_CH_SKIP;
      end
      PH_CH_SKIP: begin
        if (skip_cnt > 0) skip_cnt--;
        if (skip_cnt == 0) ph = PH_NCOUNT;
      end
      PH_NCOUNT: begin
        v = (acc > MAX_PTS) ? MAX_PTS : acc;
        data_cnt = v;
        data_idx = 0;
        push_result(KIND_HEADER, cur_type, grp8, 0, (v > 65535) ? 65535 : v, v == 0);
        if (v == 0) next_chan();
        else ph = PH_DATA;
      end
      PH_DATA: begin
        v = (acc > 65535) ? 65535 : acc;
        push_result(KIND_DATA, cur_type, grp8, data_idx, v, data_cnt == 1);
        data_idx++;
        if (data_cnt > 0) data_cnt--;
        if (data_cnt == 0) next_chan();
      end
      default: ;
    endcase
    tok_on = 1'b0;
    acc    = 0;
    live   = 4'hF;
    npos   = 0;
  endfunction

  // Results caused by one accepted byte
  function automatic void parse_byte(input logic [7:0] b);
    if (b == BYTE_STX) begin
      in_frm   = 1'b1;
      tok_on   = 1'b0;
      skip_cnt = hdr_skip;
      ph       = (hdr_skip != 0) ? PH_HEADER : PH_ENC_COUNT;
      chan_cnt = 0;
      grp8     = 1'b0;
      cur_type = TYPE_UNKNOWN;
      live     = 4'hF;
      npos     = 0;
      data_cnt = 0;
      data_idx = 0;
      acc      = 0;
      return;
    end
    if (!in_frm) return;
    if (b == BYTE_SEP) begin
      close_token();
    end else if (b == BYTE_ETX) begin
      close_token();
      push_result(KIND_END, TYPE_UNKNOWN, 1'b0, 0, 0, 1'b1);
      in_frm = 1'b0;
      ph     = PH_IDLE;
      tok_on = 1'b0;
      acc    = 0;
      live   = 4'hF;
      npos   = 0;
    end else begin
      absorb_char(b);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake side
  // ---------------------------------------------------------------------------
  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.byte_in <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_sent++;
    parse_byte(b);
  endtask

  task automatic send_tele();
    foreach (tele[i]) send_byte(tele[i]);
    tele.delete();
  endtask

  // Block idle: nothing owed and the pipeline flushed
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_header_skip(input logic [5:0] v);
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_HEADER_SKIP, 2'b00};
    pwdata  <= {26'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    hdr_skip = v;
  endtask

  // Receiver: random stalls, plus a long hold-off when asked
  initial begin : rx_side
    int unsigned stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_asked) begin
        out_if.ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
        hold_served++;
        out_if.ready <= 1'b1;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (!rx_calm) stall = pick_gap();
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endfunction

  // Compare every accepted result with the oldest one owed
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected result: kind %0d value %0d", out_if.kind, out_if.value);
        n_err++;
      end else begin
        want = parsed_q.pop_front();
        check_field("kind", want.kind, out_if.kind);
        check_field("channel_type", want.channel_type, out_if.channel_type);
        check_field("eight_bit_group", want.eight_bit_group, out_if.eight_bit_group);
        check_field("point_index", want.point_index, out_if.point_index);
        check_field("value", want.value, out_if.value);
        check_field("last", want.last, out_if.last);
      end
    end
  end

  // Watchdog: cycles with no request accepted on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Telegram building
  // ---------------------------------------------------------------------------
  task automatic put_sep();
    tele.push_back(BYTE_SEP);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 2)) tele.push_back(BYTE_SEP);
  endtask

  task automatic put_word(input string s);
    for (int i = 0; i < s.len(); i++) tele.push_back(s[i]);
    put_sep();
  endtask

  // Filler token of printable characters
  task automatic put_junk();
    repeat ($urandom_range(1, 4)) tele.push_back(8'($urandom_range(8'h21, 8'h7E)));
    put_sep();
  endtask

  // Number token in base 10 or 16, hex letters in random case
  task automatic put_num(input int unsigned v, input int unsigned base);
    logic [7:0]  digs[$];
    int unsigned d;
    do begin
      d = v % base;
      if (d < 10) digs.push_front(8'("0" + d));
      else if ($urandom_range(0, 1) != 0) digs.push_front(8'("A" + d - 10));
      else digs.push_front(8'("a" + d - 10));
      v = v / base;
    end while (v != 0);
    foreach (digs[i]) tele.push_back(digs[i]);
    put_sep();
  endtask

  task automatic put_channel(input int unsigned max_n);
    int unsigned n;
    int unsigned r;
    n = $urandom_range(0, max_n);
    r = $urandom_range(0, 9);
    if (r < 6) put_word(content_tab[r % 4]);
    else if (r == 6) put_word("DIST");
    else if (r == 7) put_word("RSSI12");
    else if (r == 8) put_word("dist1");
    else put_junk();
    repeat (4) put_junk();
    put_num(n, 16);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) put_num($urandom_range(65536, 1 << 20), 16);
      else put_num($urandom_range(0, 65535), 16);
    end
  endtask

  task automatic put_frame(input int unsigned hs, input int unsigned n_enc,
                           input int unsigned n16, input int unsigned n8,
                           input int unsigned max_n);
    tele.push_back(BYTE_STX);
    repeat (hs) put_junk();
    put_num(n_enc, 10);
    repeat (2 * n_enc) put_junk();
    put_num(n16, 10);
    repeat (n16) put_channel(max_n);
    put_num(n8, 10);
    repeat (n8) put_channel(max_n);
    if ($urandom_range(0, 4) == 0) put_junk();
  endtask

  // Close the frame, sometimes right against the last token
  task automatic end_frame();
    if (tele.size() > 0 && tele[$] == BYTE_SEP && $urandom_range(0, 1) != 0)
      void'(tele.pop_back());
    tele.push_back(BYTE_ETX);
  endtask

  task automatic strip_seps();
    while (tele.size() > 0 && tele[$] == BYTE_SEP) void'(tele.pop_back());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset value of header_skip, both groups, well-formed frame
  task automatic test_reset_skip();
    tele.push_back(BYTE_STX);
    repeat (18) put_junk();
    put_word("1");
    put_junk();
    put_junk();
    put_word("1");
    put_word("DIST1");
    repeat (4) put_junk();
    put_word("3");
    put_word("0");
    put_word("FFFF");
    put_word("1ABc");
    put_word("1");
    put_word("RSSI2");
    repeat (4) put_junk();
    put_word("0");
    end_frame();
    send_tele();
  endtask

  // Zero count, saturated value, unknown name, value closed by the end byte
  task automatic test_field_extremes();
    write_header_skip(6'd0);
    tele.push_back(BYTE_STX);
    put_word("0");
    put_word("2");
    put_word("DIST2");
    repeat (4) put_junk();
    put_word("0");
    put_word("RSSI1");
    repeat (4) put_junk();
    put_word("2");
    put_word("FFFFF");
    put_word("0");
    put_word("1");
    put_word("DIST12");
    repeat (4) put_junk();
    put_word("1");
    put_word("ff");
    strip_seps();
    tele.push_back(BYTE_ETX);
    send_tele();
  endtask

  // Signs, prefixes, stray letters, short names, extra tokens after the groups
  task automatic test_number_forms();
    tele.push_back(BYTE_STX);
    put_word("-1");
    put_word("p");
    put_word("q");
    put_word("x2");
    put_word("dist1");
    repeat (4) put_junk();
    put_word("0x1");
    put_word("g7");
    put_word("RSSI");
    repeat (4) put_junk();
    put_word("00");
    put_word("+1");
    put_word("RSSI2");
    repeat (4) put_junk();
    put_word("2");
    put_word("10");
    put_word("20");
    put_word("30");
    put_word("40");
    tele.push_back(BYTE_ETX);
    send_tele();
  endtask

  // Bytes outside frames, restart inside a frame, empty frames
  task automatic test_framing();
    write_header_skip(6'd2);
    tele = '{BYTE_ETX, 8'hFF, BYTE_SEP, 8'h41, 8'h00, 8'h80};
    tele.push_back(BYTE_STX);
    put_junk();
    put_junk();
    put_word("0");
    put_word("1");
    put_word("DIST1");
    repeat (4) put_junk();
    put_word("5");
    put_word("1");
    put_word("2");
    tele.push_back(BYTE_STX);
    put_junk();
    put_junk();
    put_word("0");
    put_word("0");
    put_word("0");
    tele.push_back(BYTE_ETX);
    tele.push_back(BYTE_STX);
    tele.push_back(BYTE_ETX);
    tele.push_back(BYTE_ETX);
    tele.push_back(BYTE_STX);
    tele.push_back(BYTE_STX);
    tele.push_back(BYTE_SEP);
    tele.push_back(BYTE_SEP);
    tele.push_back(BYTE_ETX);
    send_tele();
  endtask

  // Largest header skip, saturated channel, data and encoder counts,
  // channel cut short by the end byte
  task automatic test_saturation();
    write_header_skip(6'd63);
    tele.push_back(BYTE_STX);
    repeat (63) put_word("h");
    put_word("0");
    put_word("65537");
    put_word("RSSI2");
    repeat (4) put_junk();
    put_word("FFFFFF");
    repeat (8) put_num($urandom_range(0, 15), 16);
    end_frame();
    send_tele();
    write_header_skip(6'd0);
    tele.push_back(BYTE_STX);
    put_word("300");
    repeat (6) put_word("a");
    end_frame();
    send_tele();
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    write_header_skip(6'd0);
    tx_calm = 1'b1;
    hold_asked++;
    tele.push_back(BYTE_STX);
    put_word("0");
    put_word("1");
    put_word("DIST1");
    repeat (4) put_junk();
    put_num(12, 16);
    repeat (12) put_num($urandom_range(0, 65535), 16);
    put_word("0");
    end_frame();
    send_tele();
    tx_calm = 1'b0;
  endtask

  // Random frames under three header_skip settings
  task automatic test_random();
    int unsigned start;
    int unsigned r;
    int unsigned cut;
    logic [5:0]  setting[3];
    setting[0] = 6'($urandom_range(0, 3));
    setting[1] = 6'($urandom_range(0, 3));
    setting[2] = 6'($urandom_range(4, 12));
    foreach (setting[s]) begin
      write_header_skip(setting[s]);
      start = n_sent;
      while (n_sent - start < RAND_BYTES) begin
        tx_calm = ($urandom_range(0, 4) == 0);
        rx_calm = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        put_frame((r % 7 == 0) ? hdr_skip + 1 : hdr_skip, $urandom_range(0, 2),
                  $urandom_range(0, 2), $urandom_range(0, 2), 4);
        if (r >= 70 && r < 92) begin
          // cut short, closed by an end byte or left for the next start byte
          cut = $urandom_range(1, tele.size() - 1);
          while (tele.size() > cut) void'(tele.pop_back());
        end
        if (r < 85) begin
          end_frame();
        end else if (r >= 92) begin
          tele.delete();
          repeat ($urandom_range(1, 20)) tele.push_back(8'($urandom_range(0, 255)));
        end
        send_tele();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.byte_in = 8'h00;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_skip();
    test_field_extremes();
    test_number_forms();
    test_framing();
    test_saturation();
    test_backpressure();
    test_random();
    wait_idle();

    if (n_err == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== lidar_scan_telegram_parser_top.f =====
hdl/lstp_pkg.sv
hdl/lstp_if.sv
hdl/lstp_parse.sv
hdl/lidar_scan_telegram_parser_top.sv
verif/lidar_scan_telegram_parser_top_tb.sv
